FILE: rtl/rbme_pkg.sv
// shared types and constants of the radial brush mask erase unit
package rbme_pkg;

  // width of normalized quantities and unity in Q1.16
  localparam int          Q_W     = 17;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int RASTER_W   = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRUSH_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_STRENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RASTER_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RASTER_HEIGHT  = 3'd5;

  // one input pixel
  typedef struct packed {
    logic [11:0]        pixel_col;
    logic [11:0]        pixel_row;
    logic signed [31:0] mask_value;
  } pixel_t;

  // one result
  typedef struct packed {
    logic [30:0] erased_value;
    logic        inside_brush;
  } result_t;

  // sideband that travels with a pixel down the pipe
  typedef struct packed {
    logic [30:0] mag;
    logic        in_raster;
    logic        hit;
  } side_t;

  // clamped and derived configuration
  typedef struct packed {
    logic [RASTER_W-1:0] xden;
    logic [RASTER_W-1:0] yden;
    logic [16:0]         cx;
    logic [16:0]         cy;
    logic [16:0]         r;
    logic [16:0]         st;
  } cfg_t;

endpackage

FILE: rtl/rbme_norm.sv
// position normalization: two pipelined restoring dividers, one quotient bit per stage
module rbme_norm import rbme_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [11:0]    col_i,
  input  logic [11:0]    row_i,
  input  side_t          side_i,
  input  cfg_t           cfg_i,
  output logic           valid_o,
  output logic [Q_W-1:0] u_o,
  output logic [Q_W-1:0] v_o,
  output side_t          side_o
);

  localparam int NUM_W = 29;

  logic             vld_q  [0:Q_W];
  logic [NUM_W-1:0] nx_q   [0:Q_W];
  logic [NUM_W-1:0] ny_q   [0:Q_W];
  logic [Q_W-1:0]   qx_q   [0:Q_W];
  logic [Q_W-1:0]   qy_q   [0:Q_W];
  side_t            side_q [0:Q_W];

  // numerator stage: pos * 65536 + den / 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q[0]   <= {1'b0, col_i, 16'h0000} + NUM_W'(cfg_i.xden[RASTER_W-1:1]);
    ny_q[0]   <= {1'b0, row_i, 16'h0000} + NUM_W'(cfg_i.yden[RASTER_W-1:1]);
    qx_q[0]   <= '0;
    qy_q[0]   <= '0;
    side_q[0] <= side_i;
  end

  // one trial subtraction per stage, most significant quotient bit first
  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    localparam int B = Q_W - k;
    logic [NUM_W-1:0] trial_x;
    logic [NUM_W-1:0] trial_y;
    logic             ge_x;
    logic             ge_y;

    always_comb begin
      trial_x = NUM_W'(cfg_i.xden) << B;
      trial_y = NUM_W'(cfg_i.yden) << B;
      ge_x    = nx_q[k-1] >= trial_x;
      ge_y    = ny_q[k-1] >= trial_y;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      nx_q[k]   <= ge_x ? nx_q[k-1] - trial_x : nx_q[k-1];
      ny_q[k]   <= ge_y ? ny_q[k-1] - trial_y : ny_q[k-1];
      qx_q[k]   <= qx_q[k-1] | (Q_W'(ge_x) << B);
      qy_q[k]   <= qy_q[k-1] | (Q_W'(ge_y) << B);
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = vld_q[Q_W];
  assign u_o     = qx_q[Q_W];
  assign v_o     = qy_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

FILE: rtl/rbme_sqrt.sv
// squared distance, radius test and pipelined integer square root
module rbme_sqrt import rbme_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [Q_W-1:0] u_i,
  input  logic [Q_W-1:0] v_i,
  input  side_t          side_i,
  input  cfg_t           cfg_i,
  output logic           valid_o,
  output logic [Q_W-1:0] dist_o,
  output side_t          side_o
);

  localparam int X_W = 34;
  localparam int R_W = 35;

  logic               vld_d_q;
  logic signed [17:0] dx_q;
  logic signed [17:0] dy_q;
  side_t              side_d_q;
  logic signed [35:0] sqx;
  logic signed [35:0] sqy;
  logic [X_W-1:0]     r2;

  logic           vld_q  [0:Q_W];
  logic [X_W-1:0] x_q    [0:Q_W];
  logic [R_W-1:0] res_q  [0:Q_W];
  side_t          side_q [0:Q_W];

  // offsets from the stroke center
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q  <= 1'b0;
      vld_q[0] <= 1'b0;
    end else begin
      vld_d_q  <= valid_i;
      vld_q[0] <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= $signed({1'b0, u_i}) - $signed({1'b0, cfg_i.cx});
    dy_q     <= $signed({1'b0, v_i}) - $signed({1'b0, cfg_i.cy});
    side_d_q <= side_i;
  end

  // squared distance
  always_comb begin
    sqx = dx_q * dx_q;
    sqy = dy_q * dy_q;
    r2  = X_W'(cfg_i.r) * X_W'(cfg_i.r);
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= sqx[X_W-1:0] + sqy[X_W-1:0];
    res_q[0]  <= '0;
    side_q[0] <= side_d_q;
  end

  // digit-by-digit root, one result bit per stage
  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    localparam int J = Q_W - k;
    localparam logic [R_W-1:0] BIT = R_W'(1) << (2 * J);
    logic [R_W-1:0] sum;
    logic           ge;

    always_comb begin
      sum = res_q[k-1] + BIT;
      ge  = {1'b0, x_q[k-1]} >= sum;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[k]   <= ge ? x_q[k-1] - sum[X_W-1:0] : x_q[k-1];
      res_q[k] <= (res_q[k-1] >> 1) + (ge ? BIT : '0);
    end

    // radius test rides along the first root stage
    if (k == 1) begin : g_inside
      always_ff @(posedge clk_i) begin
        side_q[k] <= '{mag:       side_q[k-1].mag,
                       in_raster: side_q[k-1].in_raster,
                       hit:       side_q[k-1].in_raster && (x_q[k-1] <= r2)};
      end
    end else begin : g_pass
      always_ff @(posedge clk_i) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign dist_o  = res_q[Q_W][Q_W-1:0];
  assign side_o  = side_q[Q_W];

endmodule

FILE: rtl/rbme_shape.sv
// distance-to-radius divider, smoothstep falloff and sample scaling
module rbme_shape import rbme_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [Q_W-1:0] dist_i,
  input  side_t          side_i,
  input  cfg_t           cfg_i,
  output logic           valid_o,
  output result_t        result_o
);

  localparam int NUM_W  = 33;
  localparam int TAIL_N = 8;

  logic             vld_q  [0:Q_W];
  logic [NUM_W-1:0] num_q  [0:Q_W];
  logic [Q_W-1:0]   q_q    [0:Q_W];
  side_t            side_q [0:Q_W];

  logic  tvld_q  [0:TAIL_N];
  side_t tside_q [0:TAIL_N];

  logic [16:0] t_q;
  logic [32:0] tt_q;
  logic [17:0] poly_q;
  logic [50:0] s_q;
  logic [16:0] falloff_q;
  logic [33:0] e_q;
  logic [16:0] keep_q;
  logic [47:0] prod_q;
  result_t     result_q;

  logic [16:0] ratio;
  logic [50:0] s_rnd;
  logic [33:0] e_rnd;
  logic [17:0] erase;
  logic [48:0] prod_rnd;

  // ratio divider: dist * 65536 / radius
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0]  <= {dist_i, 16'h0000};
    q_q[0]    <= '0;
    side_q[0] <= side_i;
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    localparam int B = Q_W - k;
    logic [NUM_W-1:0] trial;
    logic             ge;

    always_comb begin
      trial = NUM_W'(cfg_i.r) << B;
      ge    = num_q[k-1] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k]  <= ge ? num_q[k-1] - trial : num_q[k-1];
      q_q[k]    <= q_q[k-1] | (Q_W'(ge) << B);
      side_q[k] <= side_q[k-1];
    end
  end

  // valid and sideband through the arithmetic tail
  always_comb begin
    tvld_q[0]  = vld_q[Q_W];
    tside_q[0] = side_q[Q_W];
  end

  for (genvar i = 1; i <= TAIL_N; i++) begin : g_tail
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tvld_q[i] <= 1'b0;
      end else begin
        tvld_q[i] <= tvld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      tside_q[i] <= tside_q[i-1];
    end
  end

  // rounding and clamps between tail stages
  always_comb begin
    ratio    = (q_q[Q_W] > ONE_Q16) ? ONE_Q16 : q_q[Q_W];
    s_rnd    = s_q + (51'(1) << 31);
    e_rnd    = e_q + 34'd32768;
    erase    = (e_rnd[33:16] > 18'(ONE_Q16)) ? 18'(ONE_Q16) : e_rnd[33:16];
    prod_rnd = 49'(prod_q) + 49'd32768;
  end

  // falloff t = 1 - ratio, then t*t*(3 - 2t), strength and sample scaling
  always_ff @(posedge clk_i) begin
    t_q       <= ONE_Q16 - ratio;
    tt_q      <= 33'(t_q) * 33'(t_q);
    poly_q    <= 18'd196608 - {t_q, 1'b0};
    s_q       <= 51'(tt_q) * 51'(poly_q);
    falloff_q <= s_rnd[48:32];
    e_q       <= 34'(cfg_i.st) * 34'(falloff_q);
    keep_q    <= ONE_Q16 - erase[16:0];
    prod_q    <= 48'(tside_q[6].mag) * 48'(keep_q);
    result_q.inside_brush <= tside_q[7].hit;
    result_q.erased_value <= tside_q[7].hit ? prod_rnd[46:16] : tside_q[7].mag;
  end

  assign valid_o  = tvld_q[TAIL_N];
  assign result_o = result_q;

endmodule

FILE: rtl/radial_brush_mask_erase_unit.sv
// radial brush erase: one circular smoothstep erase stroke over a stream of mask pixels
// throughput: one pixel per cycle, set by the bit-per-stage dividers and square root
// busy stays low: a new pixel may be started in every cycle
// reset: async active low, clears the pipeline valid bits and loads the register defaults
module radial_brush_mask_erase_unit import rbme_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  pixel_t                pixel_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  done_o,
  output result_t               result_o
);

  localparam int LAT = 63;

  logic [16:0]         center_x_q;
  logic [16:0]         center_y_q;
  logic [16:0]         radius_q;
  logic [16:0]         strength_q;
  logic [RASTER_W-1:0] width_q;
  logic [RASTER_W-1:0] height_q;

  logic [RASTER_W-1:0] eff_w;
  logic [RASTER_W-1:0] eff_h;
  cfg_t                cfg;
  side_t               side_in;
  logic                accept;

  logic           n_valid;
  logic [Q_W-1:0] n_u;
  logic [Q_W-1:0] n_v;
  side_t          n_side;
  logic           s_valid;
  logic [Q_W-1:0] s_dist;
  side_t          s_side;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= 17'd32768;
      center_y_q <= 17'd32768;
      radius_q   <= ONE_Q16;
      strength_q <= '0;
      width_q    <= 13'd1024;
      height_q   <= 13'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X:       center_x_q <= cfg_wdata_i;
        REG_CENTER_Y:       center_y_q <= cfg_wdata_i;
        REG_BRUSH_RADIUS:   radius_q   <= cfg_wdata_i;
        REG_ERASE_STRENGTH: strength_q <= cfg_wdata_i;
        REG_RASTER_WIDTH:   width_q    <= cfg_wdata_i[RASTER_W-1:0];
        REG_RASTER_HEIGHT:  height_q   <= cfg_wdata_i[RASTER_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped and derived configuration
  always_comb begin
    eff_w = (width_q == '0) ? RASTER_W'(1) :
            (32'(width_q) > MAX_DIM) ? RASTER_W'(MAX_DIM) : width_q;
    eff_h = (height_q == '0) ? RASTER_W'(1) :
            (32'(height_q) > MAX_DIM) ? RASTER_W'(MAX_DIM) : height_q;
    cfg.xden = (eff_w > RASTER_W'(1)) ? eff_w - RASTER_W'(1) : RASTER_W'(1);
    cfg.yden = (eff_h > RASTER_W'(1)) ? eff_h - RASTER_W'(1) : RASTER_W'(1);
    cfg.cx   = (center_x_q > ONE_Q16) ? ONE_Q16 : center_x_q;
    cfg.cy   = (center_y_q > ONE_Q16) ? ONE_Q16 : center_y_q;
    cfg.r    = (radius_q < 17'd7) ? 17'd7 : (radius_q > ONE_Q16) ? ONE_Q16 : radius_q;
    cfg.st   = (strength_q > ONE_Q16) ? ONE_Q16 : strength_q;
  end

  // input transfer and sideband
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    side_in.mag       = pixel_i.mask_value[31] ? '0 : pixel_i.mask_value[30:0];
    side_in.in_raster = ({1'b0, pixel_i.pixel_col} < eff_w) &&
                        ({1'b0, pixel_i.pixel_row} < eff_h);
    side_in.hit       = 1'b0;
  end

  rbme_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .col_i   (pixel_i.pixel_col),
    .row_i   (pixel_i.pixel_row),
    .side_i  (side_in),
    .cfg_i   (cfg),
    .valid_o (n_valid),
    .u_o     (n_u),
    .v_o     (n_v),
    .side_o  (n_side)
  );

  rbme_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_valid),
    .u_i     (n_u),
    .v_i     (n_v),
    .side_i  (n_side),
    .cfg_i   (cfg),
    .valid_o (s_valid),
    .dist_o  (s_dist),
    .side_o  (s_side)
  );

  rbme_shape u_shape (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_valid),
    .dist_i   (s_dist),
    .side_i   (s_side),
    .cfg_i    (cfg),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  // every result comes from a pixel that was started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching start");

  // a negative sample always comes out as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(pixel_i.mask_value[31], LAT) |-> result_o.erased_value == '0)
    else $error("negative sample not clamped to zero");

  // a pixel outside the raster never counts as inside the brush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.inside_brush |->
      ({1'b0, $past(pixel_i.pixel_col, LAT)} < eff_w) &&
      ({1'b0, $past(pixel_i.pixel_row, LAT)} < eff_h))
    else $error("inside flag set for a pixel outside the raster");

endmodule
